>>> hw/rtl/rcm_pkg.sv
package rcm_pkg;

  localparam int unsigned DefEntries = 8;
  localparam logic [23:0] BodyLimitRst = 24'd262144;
  localparam logic [23:0] TotalLimitRst = 24'd1048576;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_STORE  = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    OC_DONE     = 3'd0,
    OC_HIT      = 3'd1,
    OC_MISS     = 3'd2,
    OC_STORED   = 3'd3,
    OC_REJECTED = 3'd4,
    OC_IGNORED  = 3'd5
  } outcome_t;

  localparam logic CFG_BODY_LIMIT = 1'b0;
  localparam logic CFG_TOTAL_LIMIT = 1'b1;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] key;
    logic [23:0] content_len;
    logic        status_ok;
    logic        has_cache_control;
    logic [31:0] lifetime;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [2:0]  slot;
    logic [2:0]  outcome;
    logic [3:0]  entry_count;
    logic [23:0] bytes_used;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
    logic [31:0] eviction_count;
    logic [31:0] expiry_count;
    logic [31:0] reject_count;
    logic [31:0] store_count;
  } rsp_t;

endpackage

>>> hw/rtl/rcm_if.sv
interface rcm_req_if;
  logic          valid;
  logic          ready;
  rcm_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rcm_rsp_if;
  logic          valid;
  logic          ready;
  rcm_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/response_cache_manager.sv
// response cache metadata engine
// in: one beat per command (lookup, store, tick, clear); out: one result beat
// per command beat. cfg: write enable, index (0 body_limit, 1 total_limit),
// 24 bit data, written at any edge with cfg_we high; change only while idle.
// one sequencer walks the ENTRIES slots through a single compare / age unit,
// one slot per cycle. lookup and tick take one pass over the slots; clear,
// empty-key lookup and a store ignored or rejected on entry take none. a
// store takes a pass to drop a same-key entry, a pass plus the S_WRITE and
// S_FIT states per eviction and a pass to find a free slot, and one more
// pass to find the oldest entry when the table is full. in_ready is low from
// acceptance until the result beat is taken; a stalled receiver holds the
// result and the block.
// reset empties the table, zeroes byte and entry totals and all counters,
// and restores the limit registers to their defaults.
module response_cache_manager #(
  parameter int unsigned ENTRIES = rcm_pkg::DefEntries
) (
  input  logic        clk,
  input  logic        rst_n,
  rcm_req_if.sink     in_ch,
  rcm_rsp_if.source   out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data
);
  import rcm_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_FIT   = 7'b0000100,
    S_OLD   = 7'b0001000,
    S_FREE  = 7'b0010000,
    S_WRITE = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r;
  logic [23:0] body_limit_r, total_limit_r;
  req_t req_r;
  logic [ENTRIES-1:0] valid_r;
  logic [63:0] tag_r [ENTRIES];
  logic [23:0] len_r [ENTRIES];
  logic [31:0] life_r [ENTRIES];
  logic [31:0] age_r [ENTRIES];
  logic [23:0] bytes_r;
  logic [CW-1:0] cnt_r;
  logic [31:0] hit_c_r, miss_c_r, evict_c_r, exp_c_r, rej_c_r, store_c_r;
  logic [IW-1:0] idx_r;
  logic [IW-1:0] best_r;
  logic best_ok_r;
  logic found_r;
  logic [IW-1:0] slot_r;
  logic [2:0] oc_r;

  logic last;
  logic [31:0] age_inc;
  logic match;
  logic [24:0] need;
  logic [IW-1:0] victim;
  logic [23:0] sub_len;
  logic [23:0] bytes_sub;

  assign last = (idx_r == IW'(ENTRIES - 1));
  assign age_inc = age_r[idx_r] + 32'd1;
  assign match = valid_r[idx_r] && (tag_r[idx_r] == req_r.key);
  assign need = {1'b0, bytes_r} + {1'b0, req_r.content_len};
  assign victim = best_r;
  assign sub_len = len_r[victim];
  assign bytes_sub = (bytes_r >= sub_len) ? bytes_r - sub_len : 24'd0;

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.data.hit = (oc_r == OC_HIT);
  assign out_ch.data.slot = 3'(slot_r);
  assign out_ch.data.outcome = oc_r;
  assign out_ch.data.entry_count = 4'(cnt_r);
  assign out_ch.data.bytes_used = bytes_r;
  assign out_ch.data.hit_count = hit_c_r;
  assign out_ch.data.miss_count = miss_c_r;
  assign out_ch.data.eviction_count = evict_c_r;
  assign out_ch.data.expiry_count = exp_c_r;
  assign out_ch.data.reject_count = rej_c_r;
  assign out_ch.data.store_count = store_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      body_limit_r <= BodyLimitRst;
      total_limit_r <= TotalLimitRst;
      valid_r <= '0;
      bytes_r <= '0;
      cnt_r <= '0;
      hit_c_r <= '0;
      miss_c_r <= '0;
      evict_c_r <= '0;
      exp_c_r <= '0;
      rej_c_r <= '0;
      store_c_r <= '0;
      idx_r <= '0;
      best_r <= '0;
      best_ok_r <= 1'b0;
      found_r <= 1'b0;
      slot_r <= '0;
      oc_r <= OC_DONE;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_BODY_LIMIT) body_limit_r <= cfg_data;
        else total_limit_r <= cfg_data;
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            req_r <= in_ch.data;
            idx_r <= '0;
            found_r <= 1'b0;
            slot_r <= '0;
            case (in_ch.data.cmd)
              CMD_LOOKUP: begin
                if (in_ch.data.key == 64'd0) begin
                  oc_r <= OC_IGNORED;
                  state_r <= S_OUT;
                end else begin
                  oc_r <= OC_DONE;
                  state_r <= S_SCAN;
                end
              end
              CMD_STORE: begin
                if (!in_ch.data.status_ok || in_ch.data.content_len == 24'd0) begin
                  oc_r <= OC_IGNORED;
                  state_r <= S_OUT;
                end else if (in_ch.data.content_len > body_limit_r ||
                             in_ch.data.content_len > total_limit_r ||
                             (in_ch.data.has_cache_control &&
                              in_ch.data.lifetime == 32'd0)) begin
                  oc_r <= OC_REJECTED;
                  rej_c_r <= rej_c_r + 32'd1;
                  state_r <= S_OUT;
                end else begin
                  oc_r <= OC_DONE;
                  state_r <= S_SCAN;
                end
              end
              CMD_TICK: begin
                oc_r <= OC_DONE;
                state_r <= S_SCAN;
              end
              default: begin
                // clear
                valid_r <= '0;
                bytes_r <= '0;
                cnt_r <= '0;
                hit_c_r <= '0;
                miss_c_r <= '0;
                evict_c_r <= '0;
                exp_c_r <= '0;
                rej_c_r <= '0;
                store_c_r <= '0;
                oc_r <= OC_DONE;
                state_r <= S_OUT;
              end
            endcase
          end
        end
        S_SCAN: begin
          idx_r <= idx_r + IW'(1);
          case (req_r.cmd)
            CMD_LOOKUP: begin
              if (match && !found_r) begin
                found_r <= 1'b1;
                age_r[idx_r] <= '0;
                slot_r <= idx_r;
              end
              if (last) begin
                state_r <= S_OUT;
                if (found_r || match) begin
                  oc_r <= OC_HIT;
                  hit_c_r <= hit_c_r + 32'd1;
                end else begin
                  oc_r <= OC_MISS;
                  miss_c_r <= miss_c_r + 32'd1;
                end
              end
            end
            CMD_TICK: begin
              if (valid_r[idx_r]) begin
                age_r[idx_r] <= age_inc;
                if (life_r[idx_r] != 32'd0 && age_inc > life_r[idx_r]) begin
                  valid_r[idx_r] <= 1'b0;
                  bytes_r <= (bytes_r >= len_r[idx_r]) ? bytes_r - len_r[idx_r]
                                                       : 24'd0;
                  cnt_r <= cnt_r - CW'(1);
                  exp_c_r <= exp_c_r + 32'd1;
                end
              end
              if (last) state_r <= S_OUT;
            end
            default: begin
              if (match && !found_r) begin
                found_r <= 1'b1;
                valid_r[idx_r] <= 1'b0;
                bytes_r <= (bytes_r >= len_r[idx_r]) ? bytes_r - len_r[idx_r]
                                                     : 24'd0;
                cnt_r <= cnt_r - CW'(1);
              end
              if (last) state_r <= S_FIT;
            end
          endcase
        end
        S_FIT: begin
          idx_r <= '0;
          best_ok_r <= 1'b0;
          if (need > {1'b0, total_limit_r}) begin
            if (cnt_r == '0) begin
              oc_r <= OC_REJECTED;
              rej_c_r <= rej_c_r + 32'd1;
              state_r <= S_OUT;
            end else begin
              found_r <= 1'b1;
              state_r <= S_OLD;
            end
          end else begin
            found_r <= 1'b0;
            state_r <= S_FREE;
          end
        end
        S_OLD: begin
          idx_r <= idx_r + IW'(1);
          if (valid_r[idx_r] && (!best_ok_r || age_r[idx_r] > age_r[best_r])) begin
            best_r <= idx_r;
            best_ok_r <= 1'b1;
          end
          if (last) state_r <= S_WRITE;
        end
        S_WRITE: begin
          if (found_r) begin
            valid_r[victim] <= 1'b0;
            bytes_r <= bytes_sub;
            cnt_r <= cnt_r - CW'(1);
            evict_c_r <= evict_c_r + 32'd1;
            state_r <= S_FIT;
          end else begin
            valid_r[victim] <= 1'b1;
            tag_r[victim] <= req_r.key;
            len_r[victim] <= req_r.content_len;
            life_r[victim] <= req_r.lifetime;
            age_r[victim] <= '0;
            // full table: the oldest entry is evicted and replaced in place
            if (valid_r[victim]) begin
              bytes_r <= bytes_sub + req_r.content_len;
              evict_c_r <= evict_c_r + 32'd1;
            end else begin
              bytes_r <= bytes_r + req_r.content_len;
              cnt_r <= cnt_r + CW'(1);
            end
            store_c_r <= store_c_r + 32'd1;
            slot_r <= victim;
            oc_r <= OC_STORED;
            state_r <= S_OUT;
          end
        end
        S_FREE: begin
          if (!valid_r[idx_r] && !best_ok_r) begin
            best_r <= idx_r;
            best_ok_r <= 1'b1;
          end
          if (last && !best_ok_r && valid_r[idx_r]) begin
            idx_r <= '0;
            found_r <= 1'b0;
            state_r <= S_OLD;
          end else begin
            idx_r <= idx_r + IW'(1);
            if (last) state_r <= S_WRITE;
          end
        end
        S_OUT: begin
          if (out_ch.ready) state_r <= S_IDLE;
        end
        default: ;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid) else $error("ready while result pending");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(ENTRIES)) else $error("entry count overflow");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");

endmodule
